// ----- rtl/sha_pkg.sv -----
// package: sha-256 round constants, initial hash value, mode codes and state type
`default_nettype none
package sha_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned CNT_W   = 61;

    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_IDX   = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    localparam logic [1:0] MODE_ABSORB     = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FIN = 2'd1;
    localparam logic [1:0] MODE_FINISH     = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage
`default_nettype wire

// ----- rtl/sha256_stream_hasher_top.sv -----
// top level: byte-stream sha-256 hasher with one shared round unit
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: data_byte, tuser: mode
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: digest_word, tuser: word_index,
//                                             tlast: last_word
//
//  an absorb transfer loads one byte; every 64th byte starts the rounds and then the add of a block
//  finish shifts the padding through the byte path one byte a cycle, pausing for the rounds
//  of each full block, then compresses each padded block, then makes eight output transfers
//  i_rst_n is synchronous, active low; it restores the initial hash value and an empty message
//  s_axis_tready is high only in idle; a low m_axis_tready holds the current digest word
`default_nettype none
module sha256_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    sha_pkg::t_state r_state, n_state;
    logic [31:0] r_h [0:7];
    logic [31:0] n_h [0:7];
    logic [31:0] r_v [0:7];
    logic [31:0] n_v [0:7];
    logic [sha_pkg::BLOCK_W-1:0] r_blk, n_blk;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_rnd, n_rnd;
    logic [sha_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]  r_idx, n_idx;
    logic        r_mark, n_mark;
    logic        r_lenok, n_lenok;
    logic        r_ret_pad, n_ret_pad;
    logic        r_last_blk, n_last_blk;

    logic        s_fire;
    logic        push;
    logic [7:0]  push_byte;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    assign s_axis_tready = (r_state == sha_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (r_state == sha_pkg::ST_OUT);
    assign m_axis_tdata  = r_h[0];
    assign m_axis_tuser  = r_idx;
    assign m_axis_tlast  = (r_idx == sha_pkg::LAST_IDX);

    assign len_bits = {r_cnt, 3'b000};
    assign len_byte = len_bits[{3'd7 - r_pos[2:0], 3'b000} +: 8];

    // message schedule window: oldest word in the top bits
    assign w0  = r_blk[511 -: 32];
    assign w1  = r_blk[479 -: 32];
    assign w9  = r_blk[223 -: 32];
    assign w14 = r_blk[63 -: 32];
    assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    assign big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + big1 + ch + sha_pkg::ROUND_K[r_rnd] + w0;
    assign big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = big0 + maj;

    always_comb begin
        n_state    = r_state;
        n_h        = r_h;
        n_v        = r_v;
        n_blk      = r_blk;
        n_pos      = r_pos;
        n_rnd      = r_rnd;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_mark     = r_mark;
        n_lenok    = r_lenok;
        n_ret_pad  = r_ret_pad;
        n_last_blk = r_last_blk;
        push       = 1'b0;
        push_byte  = 8'h00;

        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (s_fire) begin
                    n_mark = 1'b0;
                    if (s_axis_tuser == sha_pkg::MODE_ABSORB ||
                        s_axis_tuser == sha_pkg::MODE_ABSORB_FIN) begin
                        push       = 1'b1;
                        push_byte  = s_axis_tdata;
                        n_cnt      = r_cnt + 1'b1;
                        n_ret_pad  = (s_axis_tuser == sha_pkg::MODE_ABSORB_FIN);
                        n_last_blk = 1'b0;
                        if (r_pos != sha_pkg::LAST_POS &&
                            s_axis_tuser == sha_pkg::MODE_ABSORB_FIN) begin
                            n_state = sha_pkg::ST_PAD;
                        end
                    end else if (s_axis_tuser == sha_pkg::MODE_FINISH) begin
                        n_state = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                push = 1'b1;
                if (!r_mark) begin
                    push_byte = sha_pkg::PAD_MARK;
                    n_mark    = 1'b1;
                    n_lenok   = (r_pos < sha_pkg::LEN_POS);
                end else if (r_lenok && r_pos >= sha_pkg::LEN_POS) begin
                    push_byte = len_byte;
                end
                n_ret_pad  = 1'b1;
                n_last_blk = r_mark & r_lenok;
            end
            sha_pkg::ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_blk  = {r_blk[479:0], w_new};
                n_rnd  = r_rnd + 1'b1;
                if (r_rnd == sha_pkg::LAST_ROUND) begin
                    n_state = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_idx = 3'd0;
                if (r_last_blk) begin
                    n_state = sha_pkg::ST_OUT;
                end else if (r_ret_pad) begin
                    n_state = sha_pkg::ST_PAD;
                    n_lenok = 1'b1;
                end else begin
                    n_state = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    for (int i = 0; i < 7; i++) begin
                        n_h[i] = r_h[i+1];
                    end
                    n_h[7] = sha_pkg::INIT_H[r_idx];
                    n_idx  = r_idx + 1'b1;
                    if (r_idx == sha_pkg::LAST_IDX) begin
                        n_state = sha_pkg::ST_IDLE;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = sha_pkg::ST_IDLE;
            end
        endcase

        if (push) begin
            n_blk = {r_blk[503:0], push_byte};
            n_pos = r_pos + 1'b1;
            if (r_pos == sha_pkg::LAST_POS) begin
                n_state = sha_pkg::ST_ROUND;
                n_rnd   = 6'd0;
                n_v     = r_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha_pkg::ST_IDLE;
            r_h        <= sha_pkg::INIT_H;
            r_pos      <= 6'd0;
            r_rnd      <= 6'd0;
            r_cnt      <= '0;
            r_idx      <= 3'd0;
            r_mark     <= 1'b0;
            r_lenok    <= 1'b0;
            r_ret_pad  <= 1'b0;
            r_last_blk <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_h        <= n_h;
            r_pos      <= n_pos;
            r_rnd      <= n_rnd;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_mark     <= n_mark;
            r_lenok    <= n_lenok;
            r_ret_pad  <= n_ret_pad;
            r_last_blk <= n_last_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_blk <= n_blk;
    end

endmodule
`default_nettype wire
